// ===== src/open_address_hash_table_defines.svh =====
// assertion helpers for the hash table
`ifndef OPEN_ADDRESS_HASH_TABLE_DEFINES_SVH
`define OPEN_ADDRESS_HASH_TABLE_DEFINES_SVH

`define OAHT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define OAHT_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/oaht_pkg.sv =====
package oaht_pkg;

   localparam int SLOTS_DEF       = 64;
   localparam int SLOT_W          = $clog2(SLOTS_DEF);
   localparam int KEY_BYTES_DEF   = 8;
   localparam int VALUE_BYTES_DEF = 8;
   localparam logic [63:0] MULT_RESET = 64'd31;

   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_FETCH  = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
   localparam logic [1:0] ST_FULL       = 2'd2;
   localparam logic [1:0] ST_BAD_LENGTH = 2'd3;

   function automatic logic [63:0] byte_mask(input logic [3:0] len);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < len) m[i*8 +: 8] = 8'hFF;
      end
      return m;
   endfunction

endpackage

// ===== src/oaht_front.sv =====
// Validates the request, hashes the key one byte a step and hands a job on.
module oaht_front #(
   parameter int KEY_BYTES   = oaht_pkg::KEY_BYTES_DEF,
   parameter int VALUE_BYTES = oaht_pkg::VALUE_BYTES_DEF,
   localparam int SW         = oaht_pkg::SLOT_W
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [1:0]    req_kind,
   input  logic [63:0]   req_key_bytes,
   input  logic [3:0]    req_key_length,
   input  logic [63:0]   req_value_bytes,
   input  logic [3:0]    req_value_length,
   input  logic [63:0]   mult,
   output logic          job_valid,
   input  logic          job_ready,
   output logic [1:0]    job_kind,
   output logic          job_bad,
   output logic [SW-1:0] job_home,
   output logic [63:0]   job_key,
   output logic [3:0]    job_klen,
   output logic [63:0]   job_value,
   output logic [3:0]    job_vlen
);

   typedef enum logic [1:0] {IDLE, HASH, SEND} state_type;

   state_type   state_ff, state_in;
   logic [1:0]  kind_ff, kind_in;
   logic        bad_ff, bad_in;
   logic [63:0] key_ff, key_in, val_ff, val_in, h_ff, h_in;
   logic [3:0]  klen_ff, klen_in, vlen_ff, vlen_in, idx_ff, idx_in;
   logic [1:0]  ph_ff, ph_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic [SW-1:0] home;
   logic [7:0]  b;

   assign b = key_ff[idx_ff[2:0]*8 +: 8];
   always_comb begin
      home = h_ff[SW-1:0];
      if (home == '0) home = SW'(1);
   end

   // wrapping 64-bit multiply as three 32x32 partial products, one a cycle
   always_comb begin
      case (ph_ff)
         2'd0: begin
            mul_a = h_ff[31:0]; mul_b = mult[31:0];
         end
         2'd1: begin
            mul_a = h_ff[31:0]; mul_b = mult[63:32];
         end
         default: begin
            mul_a = h_ff[63:32]; mul_b = mult[31:0];
         end
      endcase
   end
   assign prod = 64'(mul_a) * 64'(mul_b);

   assign req_ready = (state_ff == IDLE);
   assign job_valid = (state_ff == SEND);
   assign job_kind  = kind_ff;
   assign job_bad   = bad_ff;
   assign job_home  = home;
   assign job_key   = key_ff;
   assign job_klen  = klen_ff;
   assign job_value = val_ff;
   assign job_vlen  = vlen_ff;

   always_comb begin
      state_in = state_ff; kind_in = kind_ff; bad_in = bad_ff; key_in = key_ff;
      val_in = val_ff; h_in = h_ff; klen_in = klen_ff; vlen_in = vlen_ff;
      idx_in = idx_ff; ph_in = ph_ff; acc_in = acc_ff;
      case (state_ff)
         IDLE: begin
            if (req_valid && req_kind != oaht_pkg::KIND_NONE) begin
               kind_in = req_kind;
               bad_in  = (req_key_length == 4'd0) ||
                         (req_key_length > 4'(KEY_BYTES)) ||
                         (req_kind == oaht_pkg::KIND_ADD &&
                          (req_value_length == 4'd0 ||
                           req_value_length > 4'(VALUE_BYTES)));
               key_in  = req_key_bytes & oaht_pkg::byte_mask(req_key_length);
               val_in  = req_value_bytes & oaht_pkg::byte_mask(req_value_length);
               klen_in = req_key_length;
               vlen_in = req_value_length;
               h_in    = '0;
               idx_in  = '0;
               ph_in   = '0;
               state_in = bad_in ? SEND : HASH;
            end
         end
         HASH: begin
            if (idx_ff == klen_ff) state_in = SEND;
            else begin
               case (ph_ff)
                  2'd0: begin
                     acc_in = prod; ph_in = 2'd1;
                  end
                  2'd1: begin
                     acc_in = acc_ff + {prod[31:0], 32'd0}; ph_in = 2'd2;
                  end
                  default: begin
                     h_in   = acc_ff + {prod[31:0], 32'd0} + {{56{b[7]}}, b};
                     ph_in  = 2'd0;
                     idx_in = idx_ff + 4'd1;
                  end
               endcase
            end
         end
         SEND: if (job_ready) state_in = IDLE;
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= IDLE;
      else state_ff <= state_in;
      kind_ff <= kind_in; bad_ff <= bad_in; key_ff <= key_in; val_ff <= val_in;
      h_ff <= h_in; klen_ff <= klen_in; vlen_ff <= vlen_in; idx_ff <= idx_in;
      ph_ff <= ph_in; acc_ff <= acc_in;
   end

endmodule

// ===== src/oaht_queue.sv =====
// Two-entry job queue between hashing and probing.
module oaht_queue #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);

   logic [W-1:0] mem_ff [2];
   logic         wp_ff, rp_ff;
   logic [1:0]   cnt_ff;
   logic         push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end

endmodule

// ===== src/oaht_back.sv =====
// Walks the slots one at a time and updates the table.
module oaht_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_valid,
   output logic                        job_ready,
   input  logic [1:0]                  job_kind,
   input  logic                        job_bad,
   input  logic [oaht_pkg::SLOT_W-1:0] job_home,
   input  logic [63:0]                 job_key,
   input  logic [3:0]                  job_klen,
   input  logic [63:0]                 job_value,
   input  logic [3:0]                  job_vlen,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [5:0]                  rsp_slot_index,
   output logic [63:0]                 rsp_found_value,
   output logic [3:0]                  rsp_found_value_length
);

   localparam int SLOTS = oaht_pkg::SLOTS_DEF;
   localparam int SW    = oaht_pkg::SLOT_W;

   typedef enum logic [2:0] {IDLE, PROBE, CHECK, READ, DONE} state_type;

   state_type     state_ff;
   logic [SLOTS-1:0] occ_ff;
   logic [67:0]   key_mem [SLOTS];
   logic [67:0]   val_mem [SLOTS];
   logic [67:0]   krd_ff, vrd_ff;
   logic [SW-1:0] p_ff, pn;
   logic [SW:0]   n_ff;
   logic [1:0]    st_ff;
   logic [SW-1:0] slot_ff;
   logic          fetch_ff;

   assign pn = (p_ff == SW'(SLOTS - 1)) ? SW'(1) : p_ff + SW'(1);
   // the job stays at the queue head until its response is taken
   assign job_ready = (state_ff == DONE) && rsp_ready;
   assign rsp_valid = (state_ff == DONE);
   assign rsp_status = st_ff;
   assign rsp_slot_index = 6'(slot_ff);
   assign rsp_found_value = fetch_ff ? vrd_ff[63:0] : 64'd0;
   assign rsp_found_value_length = fetch_ff ? vrd_ff[67:64] : 4'd0;

   always_ff @(posedge clock) begin
      krd_ff <= key_mem[p_ff];
      vrd_ff <= val_mem[slot_ff];
      if (state_ff == IDLE && job_valid && !job_bad &&
          job_kind == oaht_pkg::KIND_ADD && !occ_ff[job_home]) begin
         key_mem[job_home] <= {job_klen, job_key};
         val_mem[job_home] <= {job_vlen, job_value};
      end else if (state_ff == PROBE && job_kind == oaht_pkg::KIND_ADD && !occ_ff[pn]) begin
         key_mem[pn] <= {job_klen, job_key};
         val_mem[pn] <= {job_vlen, job_value};
      end
      if (reset) begin
         state_ff <= IDLE;
         occ_ff   <= '0;
         fetch_ff <= 1'b0;
      end else begin
         case (state_ff)
            IDLE: if (job_valid) begin
               p_ff <= job_home;
               n_ff <= '0;
               fetch_ff <= 1'b0;
               if (job_bad) begin
                  st_ff <= oaht_pkg::ST_BAD_LENGTH; slot_ff <= '0; state_ff <= DONE;
               end else if (job_kind == oaht_pkg::KIND_ADD) begin
                  if (!occ_ff[job_home]) begin
                     occ_ff[job_home] <= 1'b1;
                     st_ff <= oaht_pkg::ST_OK; slot_ff <= job_home; state_ff <= DONE;
                  end else state_ff <= PROBE;
               end else state_ff <= CHECK;
            end
            PROBE: begin
               // add: n counts occupied slots seen past the home slot
               if (n_ff == (SW+1)'(SLOTS - 2)) begin
                  st_ff <= oaht_pkg::ST_FULL; slot_ff <= '0; state_ff <= DONE;
               end else if (!occ_ff[pn]) begin
                  occ_ff[pn] <= 1'b1;
                  st_ff <= oaht_pkg::ST_OK; slot_ff <= pn; state_ff <= DONE;
               end else begin
                  p_ff <= pn; n_ff <= n_ff + (SW+1)'(1);
               end
            end
            CHECK: begin
               // krd holds key of p_ff; read while n_ff[0] is 0, then compare
               if (n_ff[0] == 1'b0) n_ff <= {n_ff[SW:1], 1'b1};
               else if (occ_ff[p_ff] && krd_ff == {job_klen, job_key}) begin
                  st_ff <= oaht_pkg::ST_OK; slot_ff <= p_ff;
                  if (job_kind == oaht_pkg::KIND_REMOVE) begin
                     occ_ff[p_ff] <= 1'b0; state_ff <= DONE;
                  end else state_ff <= READ;
               end else if (n_ff[SW:1] == SW'(SLOTS - 2)) begin
                  st_ff <= oaht_pkg::ST_NOT_FOUND; slot_ff <= '0; state_ff <= DONE;
               end else begin
                  p_ff <= pn; n_ff <= {n_ff[SW:1] + SW'(1), 1'b0};
               end
            end
            READ: begin
               fetch_ff <= 1'b1; state_ff <= DONE;
            end
            DONE: if (rsp_ready) state_ff <= IDLE;
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule

// ===== src/open_address_hash_table.sv =====
// Open-addressed key/value table, linear probing, slot 0 unused.
// Requests (req_*) carry add/remove/fetch with key and value; each valid
// transaction of kind 0..2 yields one response on rsp_*, kind 3 yields none.
// csr_* writes the 64-bit hash multiplier; write only while idle.
// Hashing takes three 32x32 partial products per key byte in the front
// end. The back end places an add into a free home slot directly, walks
// on one slot per occupied slot probed, and on remove/fetch reads and then
// compares each slot in turn, with one more read step for a fetch.
// A two-entry queue sits between front and back, so hashing of the next
// request overlaps the probe of the current one; the job at the head leaves
// the queue when its response is taken.
// Reset clears all occupied bits at once and restores the multiplier
// to 31; no clearing pass. A stalled rsp_ready holds the response and
// back-pressures the queue and then req_ready.
`include "open_address_hash_table_defines.svh"
module open_address_hash_table #(
   parameter int KEY_BYTES   = oaht_pkg::KEY_BYTES_DEF,
   parameter int VALUE_BYTES = oaht_pkg::VALUE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [63:0] req_key_bytes,
   input  logic [3:0]  req_key_length,
   input  logic [63:0] req_value_bytes,
   input  logic [3:0]  req_value_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_slot_index,
   output logic [63:0] rsp_found_value,
   output logic [3:0]  rsp_found_value_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [63:0] csr_data
);

   localparam int SW = oaht_pkg::SLOT_W;
   localparam int QW = 2 + 1 + SW + 64 + 4 + 64 + 4;

   logic [63:0] mult_ff;
   logic        f_valid, f_ready, b_valid, b_ready;
   logic [1:0]  f_kind, b_kind;
   logic        f_bad, b_bad;
   logic [SW-1:0] f_home, b_home;
   logic [63:0] f_key, b_key, f_val, b_val;
   logic [3:0]  f_klen, b_klen, f_vlen, b_vlen;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) mult_ff <= oaht_pkg::MULT_RESET;
      else if (csr_valid) mult_ff <= csr_data;
   end

   oaht_front #(.KEY_BYTES(KEY_BYTES), .VALUE_BYTES(VALUE_BYTES)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_kind, .req_key_bytes,
      .req_key_length, .req_value_bytes, .req_value_length, .mult(mult_ff),
      .job_valid(f_valid), .job_ready(f_ready), .job_kind(f_kind), .job_bad(f_bad),
      .job_home(f_home), .job_key(f_key), .job_klen(f_klen), .job_value(f_val),
      .job_vlen(f_vlen));

   oaht_queue #(.W(QW)) u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready),
      .in_data({f_kind, f_bad, f_home, f_key, f_klen, f_val, f_vlen}),
      .out_valid(b_valid), .out_ready(b_ready),
      .out_data({b_kind, b_bad, b_home, b_key, b_klen, b_val, b_vlen}));

   oaht_back u_back (
      .clock, .reset, .job_valid(b_valid), .job_ready(b_ready), .job_kind(b_kind),
      .job_bad(b_bad), .job_home(b_home), .job_key(b_key), .job_klen(b_klen),
      .job_value(b_val), .job_vlen(b_vlen), .rsp_valid, .rsp_ready, .rsp_status,
      .rsp_slot_index, .rsp_found_value, .rsp_found_value_length);

   `OAHT_ASSERT(a_fail_slot0, clock, reset,
      rsp_valid && rsp_status != oaht_pkg::ST_OK |-> rsp_slot_index == 6'd0,
      "failed response with nonzero slot")
   `OAHT_ASSERT(a_ok_slot, clock, reset,
      rsp_valid && rsp_status == oaht_pkg::ST_OK |-> rsp_slot_index != 6'd0,
      "ok response on slot 0")
   `OAHT_ASSERT(a_len, clock, reset,
      rsp_valid |-> rsp_found_value_length <= 4'(VALUE_BYTES),
      "value length out of range")
   `OAHT_ASSERT_RST(a_reset_idle, clock, $past(reset) |-> !rsp_valid,
      "response straight after reset")

endmodule
